/* hw/rtl/brh_pkg.sv */
// Shared constants and types for the Bresenham ray hit test block.
// No dependencies.
package brh_pkg;

  localparam int SLOTS_DEF      = 8;
  localparam int COORD_BITS_DEF = 12;
  localparam int SLOT_FIELD_W   = 3;
  localparam int SELF_FIELD_W   = 4;
  localparam int SIZE_W         = 8;
  // Width used when comparing slot numbers against SLOTS (max 255).
  localparam int SLOT_CMP_W     = 8;

  localparam logic FUNC_WRITE = 1'b0;
  localparam logic FUNC_CAST  = 1'b1;

  // Controls from the sequencer to the line walker.
  typedef struct packed {
    logic load;
    logic adv;
  } walk_ctrl_t;

endpackage

/* hw/rtl/brh_slots.sv */
// Rectangle slot table with per-slot active flags and a parallel point test.
// Depends on brh_pkg.
module brh_slots
  import brh_pkg::*;
#(
  parameter int SLOTS      = SLOTS_DEF,
  parameter int COORD_BITS = COORD_BITS_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         wr_en,
  input  logic [SLOT_FIELD_W-1:0]      wr_slot,
  input  logic                         wr_active,
  input  logic signed [COORD_BITS-1:0] wr_x,
  input  logic signed [COORD_BITS-1:0] wr_y,
  input  logic [SIZE_W-1:0]            wr_w,
  input  logic [SIZE_W-1:0]            wr_h,
  input  logic signed [COORD_BITS-1:0] pt_x,
  input  logic signed [COORD_BITS-1:0] pt_y,
  input  logic [SELF_FIELD_W-1:0]      self_slot,
  output logic                         hit
);

  localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int EXT_W = COORD_BITS + 1;

  logic                         on_r  [SLOTS];
  logic signed [COORD_BITS-1:0] bx_r  [SLOTS];
  logic signed [COORD_BITS-1:0] by_r  [SLOTS];
  logic [SIZE_W-1:0]            bw_r  [SLOTS];
  logic [SIZE_W-1:0]            bh_r  [SLOTS];
  logic [SLOTS-1:0]             hit_vec;

  logic             wr_ok;
  logic [IDX_W-1:0] wr_idx;

  assign wr_ok  = wr_en &&
                  ({{(SLOT_CMP_W-SLOT_FIELD_W){1'b0}}, wr_slot} < SLOT_CMP_W'(SLOTS));
  assign wr_idx = IDX_W'(wr_slot);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < SLOTS; k++) begin
        on_r[k] <= 1'b0;
      end
    end else if (wr_ok) begin
      on_r[wr_idx] <= wr_active;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_ok) begin
      bx_r[wr_idx] <= wr_x;
      by_r[wr_idx] <= wr_y;
      bw_r[wr_idx] <= wr_w;
      bh_r[wr_idx] <= wr_h;
    end
  end

  // Half-open test x <= px < x+w, y <= py < y+h, one comparator set per slot.
  for (genvar k = 0; k < SLOTS; k++) begin : g_cmp
    logic signed [EXT_W-1:0] x_lo, y_lo, x_hi, y_hi, px_e, py_e;
    logic                    not_self;
    assign x_lo = EXT_W'(bx_r[k]);
    assign y_lo = EXT_W'(by_r[k]);
    assign x_hi = x_lo + $signed({{(EXT_W-SIZE_W){1'b0}}, bw_r[k]});
    assign y_hi = y_lo + $signed({{(EXT_W-SIZE_W){1'b0}}, bh_r[k]});
    assign px_e = EXT_W'(pt_x);
    assign py_e = EXT_W'(pt_y);
    assign not_self = (SLOT_CMP_W'(k) !=
                       {{(SLOT_CMP_W-SELF_FIELD_W){1'b0}}, self_slot});
    assign hit_vec[k] = on_r[k] && not_self &&
                        (px_e >= x_lo) && (px_e < x_hi) &&
                        (py_e >= y_lo) && (py_e < y_hi);
  end

  assign hit = |hit_vec;

endmodule

/* hw/rtl/brh_walk.sv */
// Bresenham line stepper: holds the current point and error term, one step per advance.
// Depends on brh_pkg.
module brh_walk
  import brh_pkg::*;
#(
  parameter int COORD_BITS = COORD_BITS_DEF
) (
  input  logic                         clk,
  input  walk_ctrl_t                   ctrl,
  input  logic signed [COORD_BITS-1:0] start_x,
  input  logic signed [COORD_BITS-1:0] start_y,
  input  logic signed [COORD_BITS-1:0] end_x,
  input  logic signed [COORD_BITS-1:0] end_y,
  output logic signed [COORD_BITS-1:0] pt_x,
  output logic signed [COORD_BITS-1:0] pt_y,
  output logic                         at_end
);

  // Error term stays within about +-2^COORD_BITS; two guard bits for 2*err.
  localparam int ERR_W = COORD_BITS + 3;

  logic signed [COORD_BITS-1:0] x_r, y_r, ex_r, ey_r;
  logic signed [COORD_BITS-1:0] x_nxt, y_nxt, ex_nxt, ey_nxt;
  logic signed [ERR_W-1:0]      dx_r, dy_r, err_r;
  logic signed [ERR_W-1:0]      dx_nxt, dy_nxt, err_nxt;
  logic                         sxn_r, syn_r, sxn_nxt, syn_nxt;

  logic signed [ERR_W-1:0] x0e, x1e, y0e, y1e, ldx, ldy, e2, err_a;
  logic                    step_x, step_y;

  always_comb begin
    x0e = ERR_W'(start_x);
    x1e = ERR_W'(end_x);
    y0e = ERR_W'(start_y);
    y1e = ERR_W'(end_y);
    ldx = (x1e > x0e) ? (x1e - x0e) : (x0e - x1e);
    ldy = (y1e > y0e) ? (y0e - y1e) : (y1e - y0e);

    e2     = err_r <<< 1;
    step_x = (e2 >= dy_r);
    step_y = (e2 <= dx_r);
    err_a  = err_r + (step_x ? dy_r : '0) + (step_y ? dx_r : '0);

    x_nxt   = x_r;
    y_nxt   = y_r;
    ex_nxt  = ex_r;
    ey_nxt  = ey_r;
    dx_nxt  = dx_r;
    dy_nxt  = dy_r;
    err_nxt = err_r;
    sxn_nxt = sxn_r;
    syn_nxt = syn_r;
    if (ctrl.load) begin
      x_nxt   = start_x;
      y_nxt   = start_y;
      ex_nxt  = end_x;
      ey_nxt  = end_y;
      dx_nxt  = ldx;
      dy_nxt  = ldy;
      err_nxt = ldx + ldy;
      sxn_nxt = !(start_x < end_x);
      syn_nxt = !(start_y < end_y);
    end else if (ctrl.adv) begin
      err_nxt = err_a;
      if (step_x) begin
        x_nxt = sxn_r ? (x_r - COORD_BITS'(1)) : (x_r + COORD_BITS'(1));
      end
      if (step_y) begin
        y_nxt = syn_r ? (y_r - COORD_BITS'(1)) : (y_r + COORD_BITS'(1));
      end
    end
  end

  always_ff @(posedge clk) begin
    x_r   <= x_nxt;
    y_r   <= y_nxt;
    ex_r  <= ex_nxt;
    ey_r  <= ey_nxt;
    dx_r  <= dx_nxt;
    dy_r  <= dy_nxt;
    err_r <= err_nxt;
    sxn_r <= sxn_nxt;
    syn_r <= syn_nxt;
  end

  assign pt_x   = x_r;
  assign pt_y   = y_r;
  assign at_end = (x_r == ex_r) && (y_r == ey_r);

endmodule

/* hw/rtl/bresenham_ray_hit_test_top.sv */
// Top level of the Bresenham ray hit test: sequencer, slot table, line walker.
// Depends on brh_pkg, brh_slots, brh_walk.
//
// Usage:
//   Input channel (in_valid / in_stall) carries one transaction per item.
//   in_func = write: loads rectangle slot in_slot with in_box_* and the
//   active flag; the result is all zero. in_func = cast: walks a Bresenham
//   line from in_start_* toward in_end_*, testing each point short of the
//   end against every active slot except in_self_slot (parallel compare).
//   Output channel (out_valid / out_stall) returns one transaction per item:
//   stop point and blocked flag.
// Sequence (a cast steps at most max(|dx|,|dy|) points before the stop):
//   Write: IDLE, then FIN, then the output register; next input taken in IDLE.
//   Cast: IDLE, then WALK until the end or a hit, then FIN, then the output register.
//   in_stall is high from acceptance until the result enters the output
//   register; a new item is taken while that result still waits.
// Reset: synchronous, active low; clears all slot active flags, the
//   sequencer and out_valid. Rectangle contents are undefined until written.
// Stall: a held result stays in the output register; a finished result
//   behind it waits in the sequencer and the input stays stalled.
module bresenham_ray_hit_test_top
  import brh_pkg::*;
#(
  parameter int SLOTS      = SLOTS_DEF,
  parameter int COORD_BITS = COORD_BITS_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic                         in_func,
  input  logic [SLOT_FIELD_W-1:0]      in_slot,
  input  logic                         in_slot_active,
  input  logic signed [COORD_BITS-1:0] in_box_x,
  input  logic signed [COORD_BITS-1:0] in_box_y,
  input  logic [SIZE_W-1:0]            in_box_w,
  input  logic [SIZE_W-1:0]            in_box_h,
  input  logic signed [COORD_BITS-1:0] in_start_x,
  input  logic signed [COORD_BITS-1:0] in_start_y,
  input  logic signed [COORD_BITS-1:0] in_end_x,
  input  logic signed [COORD_BITS-1:0] in_end_y,
  input  logic [SELF_FIELD_W-1:0]      in_self_slot,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic signed [COORD_BITS-1:0] out_stop_x,
  output logic signed [COORD_BITS-1:0] out_stop_y,
  output logic                         out_blocked
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_WALK,
    ST_FIN
  } state_t;

  state_t state_r, state_nxt;

  logic [SELF_FIELD_W-1:0]      self_r, self_nxt;
  logic signed [COORD_BITS-1:0] res_x_r, res_y_r, res_x_nxt, res_y_nxt;
  logic                         res_blk_r, res_blk_nxt;
  logic                         out_valid_r, out_valid_nxt;
  logic signed [COORD_BITS-1:0] out_x_r, out_y_r, out_x_nxt, out_y_nxt;
  logic                         out_blk_r, out_blk_nxt;

  logic                         accept, wr_en, pt_hit, at_end, out_free;
  logic signed [COORD_BITS-1:0] pt_x, pt_y;
  walk_ctrl_t                   wctrl;

  assign in_stall = (state_r != ST_IDLE);
  assign accept   = in_valid && !in_stall;
  assign wr_en    = accept && (in_func == FUNC_WRITE);
  assign out_free = !out_valid_r || !out_stall;

  assign wctrl.load = accept && (in_func == FUNC_CAST);
  assign wctrl.adv  = (state_r == ST_WALK) && !at_end && !pt_hit;

  brh_slots #(
    .SLOTS      (SLOTS),
    .COORD_BITS (COORD_BITS)
  ) u_slots (
    .clk       (clk),
    .rst_n     (rst_n),
    .wr_en     (wr_en),
    .wr_slot   (in_slot),
    .wr_active (in_slot_active),
    .wr_x      (in_box_x),
    .wr_y      (in_box_y),
    .wr_w      (in_box_w),
    .wr_h      (in_box_h),
    .pt_x      (pt_x),
    .pt_y      (pt_y),
    .self_slot (self_r),
    .hit       (pt_hit)
  );

  brh_walk #(
    .COORD_BITS (COORD_BITS)
  ) u_walk (
    .clk     (clk),
    .ctrl    (wctrl),
    .start_x (in_start_x),
    .start_y (in_start_y),
    .end_x   (in_end_x),
    .end_y   (in_end_y),
    .pt_x    (pt_x),
    .pt_y    (pt_y),
    .at_end  (at_end)
  );

  always_comb begin
    state_nxt     = state_r;
    self_nxt      = self_r;
    res_x_nxt     = res_x_r;
    res_y_nxt     = res_y_r;
    res_blk_nxt   = res_blk_r;
    out_valid_nxt = out_valid_r;
    out_x_nxt     = out_x_r;
    out_y_nxt     = out_y_r;
    out_blk_nxt   = out_blk_r;

    // Output register drains when the receiver takes the transaction.
    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          self_nxt = in_self_slot;
          if (in_func == FUNC_WRITE) begin
            res_x_nxt   = '0;
            res_y_nxt   = '0;
            res_blk_nxt = 1'b0;
            state_nxt   = ST_FIN;
          end else begin
            state_nxt = ST_WALK;
          end
        end
      end
      ST_WALK: begin
        // End point is never tested; otherwise stop on the first hit.
        if (at_end || pt_hit) begin
          res_x_nxt   = pt_x;
          res_y_nxt   = pt_y;
          res_blk_nxt = !at_end;
          state_nxt   = ST_FIN;
        end
      end
      ST_FIN: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_x_nxt     = res_x_r;
          out_y_nxt     = res_y_r;
          out_blk_nxt   = res_blk_r;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      self_r      <= self_nxt;
      res_x_r     <= res_x_nxt;
      res_y_r     <= res_y_nxt;
      res_blk_r   <= res_blk_nxt;
      out_x_r     <= out_x_nxt;
      out_y_r     <= out_y_nxt;
      out_blk_r   <= out_blk_nxt;
    end
  end

  assign out_valid   = out_valid_r;
  assign out_stop_x  = out_x_r;
  assign out_stop_y  = out_y_r;
  assign out_blocked = out_blk_r;

endmodule

/* test/brh_hit_checker.sv */
// Result checker for the Bresenham ray hit test: watches both channels,
// predicts every stop point from a private slot table and compares.
// Depends on brh_pkg.
module brh_hit_checker
  import brh_pkg::*;
#(
  parameter int SLOTS      = SLOTS_DEF,
  parameter int COORD_BITS = COORD_BITS_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  input  logic                         in_stall,
  input  logic                         in_func,
  input  logic [SLOT_FIELD_W-1:0]      in_slot,
  input  logic                         in_slot_active,
  input  logic signed [COORD_BITS-1:0] in_box_x,
  input  logic signed [COORD_BITS-1:0] in_box_y,
  input  logic [SIZE_W-1:0]            in_box_w,
  input  logic [SIZE_W-1:0]            in_box_h,
  input  logic signed [COORD_BITS-1:0] in_start_x,
  input  logic signed [COORD_BITS-1:0] in_start_y,
  input  logic signed [COORD_BITS-1:0] in_end_x,
  input  logic signed [COORD_BITS-1:0] in_end_y,
  input  logic [SELF_FIELD_W-1:0]      in_self_slot,
  input  logic                         out_valid,
  input  logic                         out_stall,
  input  logic signed [COORD_BITS-1:0] out_stop_x,
  input  logic signed [COORD_BITS-1:0] out_stop_y,
  input  logic                         out_blocked,
  output int                           stops_owed,
  output int                           mismatch_cnt
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    logic signed [COORD_BITS-1:0] x;
    logic signed [COORD_BITS-1:0] y;
    logic                         blk;
  } stop_rec_t;

  // Shadow of the rectangle table
  logic on_tbl [SLOTS];
  int   bx_tbl [SLOTS];
  int   by_tbl [SLOTS];
  int   bw_tbl [SLOTS];
  int   bh_tbl [SLOTS];

  stop_rec_t stop_q [$];
  stop_rec_t want;

  // Half-open point test against every active slot but the caster's
  function automatic bit covers(int px, int py, logic [SELF_FIELD_W-1:0] skip);
    for (int k = 0; k < SLOTS; k++) begin
      if (on_tbl[k] && k != int'(skip) &&
          px >= bx_tbl[k] && px < bx_tbl[k] + bw_tbl[k] &&
          py >= by_tbl[k] && py < by_tbl[k] + bh_tbl[k])
        return 1'b1;
    end
    return 1'b0;
  endfunction

  function automatic stop_rec_t trace_ray(int x0, int y0, int x1, int y1,
                                          logic [SELF_FIELD_W-1:0] skip);
    int dx, dy, sx, sy, err, e2, n;
    stop_rec_t r;
    dx    = (x1 > x0) ? x1 - x0 : x0 - x1;
    sx    = (x0 < x1) ? 1 : -1;
    dy    = (y1 > y0) ? y0 - y1 : y1 - y0;   // negative magnitude
    sy    = (y0 < y1) ? 1 : -1;
    err   = dx + dy;
    r.blk = 1'b0;
    for (n = 0; n < dx - dy + 1; n++) begin
      if (x0 == x1 && y0 == y1) break;
      if (covers(x0, y0, skip)) begin
        r.blk = 1'b1;
        break;
      end
      e2 = 2 * err;
      if (e2 >= dy) begin
        err += dy;
        x0  += sx;
      end
      if (e2 <= dx) begin
        err += dx;
        y0  += sy;
      end
    end
    r.x = x0[COORD_BITS-1:0];
    r.y = y0[COORD_BITS-1:0];
    return r;
  endfunction

  initial mismatch_cnt = 0;
  initial stops_owed = 0;

  always @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < SLOTS; k++) on_tbl[k] = 1'b0;
      stop_q.delete();
    end else begin
      if (out_valid && !out_stall) begin
        if (stop_q.size() == 0) begin
          $error("result with nothing outstanding: stop_x %0d stop_y %0d blocked %0b",
                 out_stop_x, out_stop_y, out_blocked);
          mismatch_cnt++;
        end else begin
          want = stop_q.pop_front();
          if (out_stop_x !== want.x) begin
            $error("stop_x: expected %0d, got %0d", want.x, out_stop_x);
            mismatch_cnt++;
          end
          if (out_stop_y !== want.y) begin
            $error("stop_y: expected %0d, got %0d", want.y, out_stop_y);
            mismatch_cnt++;
          end
          if (out_blocked !== want.blk) begin
            $error("blocked: expected %0b, got %0b", want.blk, out_blocked);
            mismatch_cnt++;
          end
        end
      end
      if (in_valid && !in_stall) begin
        if (in_func == FUNC_WRITE) begin
          if (int'(in_slot) < SLOTS) begin
            on_tbl[in_slot] = in_slot_active;
            bx_tbl[in_slot] = int'(in_box_x);
            by_tbl[in_slot] = int'(in_box_y);
            bw_tbl[in_slot] = int'(in_box_w);
            bh_tbl[in_slot] = int'(in_box_h);
          end
          want.x   = '0;
          want.y   = '0;
          want.blk = 1'b0;
        end else begin
          want = trace_ray(int'(in_start_x), int'(in_start_y),
                           int'(in_end_x), int'(in_end_y), in_self_slot);
        end
        stop_q.push_back(want);
      end
    end
    stops_owed <= stop_q.size();
  end

endmodule

/* test/tb_bresenham_ray_hit_test_top.sv */
// Testbench top for the Bresenham ray hit test: clock, reset, stimulus,
// result sink with random stalls, and the verdict.
// Depends on brh_pkg, bresenham_ray_hit_test_top and brh_hit_checker.
module tb_bresenham_ray_hit_test_top;
  import brh_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CB   = COORD_BITS_DEF;
  localparam int CMIN = -(1 << (CB - 1));
  localparam int CMAX = (1 << (CB - 1)) - 1;
  localparam int SELF_NONE = SLOTS_DEF;   // caster owns no slot
  // A run holds the directed items, 1450 random transactions with gaps and
  // stalls, among them a few dozen long rays across the world, and two long holds.
  // The ceiling sits above the length of that run.
  localparam int CYCLE_LIMIT = 2_000_000;

  // One input transaction, all fields
  typedef struct {
    logic                    func;
    logic [SLOT_FIELD_W-1:0] slot;
    logic                    act;
    logic [CB-1:0]           bx;
    logic [CB-1:0]           by;
    logic [SIZE_W-1:0]       bw;
    logic [SIZE_W-1:0]       bh;
    logic [CB-1:0]           sx;
    logic [CB-1:0]           sy;
    logic [CB-1:0]           ex;
    logic [CB-1:0]           ey;
    logic [SELF_FIELD_W-1:0] self_id;
  } ray_txn_t;

  logic                    clk;
  logic                    rst_n;
  logic                    in_valid;
  logic                    in_stall;
  logic                    in_func;
  logic [SLOT_FIELD_W-1:0] in_slot;
  logic                    in_slot_active;
  logic signed [CB-1:0]    in_box_x;
  logic signed [CB-1:0]    in_box_y;
  logic [SIZE_W-1:0]       in_box_w;
  logic [SIZE_W-1:0]       in_box_h;
  logic signed [CB-1:0]    in_start_x;
  logic signed [CB-1:0]    in_start_y;
  logic signed [CB-1:0]    in_end_x;
  logic signed [CB-1:0]    in_end_y;
  logic [SELF_FIELD_W-1:0] in_self_slot;
  logic                    out_valid;
  logic                    out_stall;
  logic signed [CB-1:0]    out_stop_x;
  logic signed [CB-1:0]    out_stop_y;
  logic                    out_blocked;

  int stops_owed;     // results predicted but not yet seen
  int mismatch_cnt;
  int cycle_cnt;
  bit burst;          // sender offers back to back when set

  bresenham_ray_hit_test_top u_dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_func        (in_func),
    .in_slot        (in_slot),
    .in_slot_active (in_slot_active),
    .in_box_x       (in_box_x),
    .in_box_y       (in_box_y),
    .in_box_w       (in_box_w),
    .in_box_h       (in_box_h),
    .in_start_x     (in_start_x),
    .in_start_y     (in_start_y),
    .in_end_x       (in_end_x),
    .in_end_y       (in_end_y),
    .in_self_slot   (in_self_slot),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_stop_x     (out_stop_x),
    .out_stop_y     (out_stop_y),
    .out_blocked    (out_blocked)
  );

  brh_hit_checker u_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_func        (in_func),
    .in_slot        (in_slot),
    .in_slot_active (in_slot_active),
    .in_box_x       (in_box_x),
    .in_box_y       (in_box_y),
    .in_box_w       (in_box_w),
    .in_box_h       (in_box_h),
    .in_start_x     (in_start_x),
    .in_start_y     (in_start_y),
    .in_end_x       (in_end_x),
    .in_end_y       (in_end_y),
    .in_self_slot   (in_self_slot),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_stop_x     (out_stop_x),
    .out_stop_y     (out_stop_y),
    .out_blocked    (out_blocked),
    .stops_owed     (stops_owed),
    .mismatch_cnt   (mismatch_cnt)
  );

  // 4 ns clock
  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Run ceiling: if the block hangs, the run ends here with a failure.
  initial begin
    cycle_cnt = 0;
    while (cycle_cnt < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_cnt++;
    end
    $display("== FAIL ==");
    $finish;
  end

  // Uniform coordinate over the whole signed range
  function automatic int rnd_coord();
    return int'($urandom_range(0, CMAX - CMIN)) + CMIN;
  endfunction

  // Random point within +/- span of c, clipped to the coordinate range
  function automatic int nudge(int c, int span);
    int v;
    v = c + int'($urandom_range(0, 2 * span)) - span;
    if (v < CMIN) v = CMIN;
    if (v > CMAX) v = CMAX;
    return v;
  endfunction

  // Slot write; the ray fields carry random junk the block must ignore
  function automatic ray_txn_t mk_write(int slot, bit act, int x, int y, int w, int h);
    ray_txn_t t;
    t.func    = FUNC_WRITE;
    t.slot    = slot[SLOT_FIELD_W-1:0];
    t.act     = act;
    t.bx      = x[CB-1:0];
    t.by      = y[CB-1:0];
    t.bw      = w[SIZE_W-1:0];
    t.bh      = h[SIZE_W-1:0];
    t.sx      = CB'($urandom());
    t.sy      = CB'($urandom());
    t.ex      = CB'($urandom());
    t.ey      = CB'($urandom());
    t.self_id = SELF_FIELD_W'($urandom());
    return t;
  endfunction

  // Ray cast; the box fields carry random junk
  function automatic ray_txn_t mk_cast(int sx, int sy, int ex, int ey, int self_id);
    ray_txn_t t;
    t.func    = FUNC_CAST;
    t.slot    = SLOT_FIELD_W'($urandom());
    t.act     = 1'($urandom());
    t.bx      = CB'($urandom());
    t.by      = CB'($urandom());
    t.bw      = SIZE_W'($urandom());
    t.bh      = SIZE_W'($urandom());
    t.sx      = sx[CB-1:0];
    t.sy      = sy[CB-1:0];
    t.ex      = ex[CB-1:0];
    t.ey      = ey[CB-1:0];
    t.self_id = self_id[SELF_FIELD_W-1:0];
    return t;
  endfunction

  // Present one transaction after a random gap and hold it until taken.
  // Returns on the accepting edge with in_valid still high, so the next
  // call can keep valid up with no bubble when it draws a zero gap.
  task automatic offer(input ray_txn_t t);
    int gap;
    gap = burst ? 0 : int'($urandom_range(0, 13));
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid       <= 1'b1;
    in_func        <= t.func;
    in_slot        <= t.slot;
    in_slot_active <= t.act;
    in_box_x       <= t.bx;
    in_box_y       <= t.by;
    in_box_w       <= t.bw;
    in_box_h       <= t.bh;
    in_start_x     <= t.sx;
    in_start_y     <= t.sy;
    in_end_x       <= t.ex;
    in_end_y       <= t.ey;
    in_self_slot   <= t.self_id;
    do @(posedge clk); while (in_stall);
  endtask

  // Stop offering and wait until every predicted result has come back.
  // The first look comes after the next edge, so the checker has counted the
  // last accepted transaction.
  task automatic drain();
    in_valid <= 1'b0;
    do @(posedge clk); while (stops_owed != 0);
  endtask

  // Result sink: a fresh stall length per result, calm stretches with no
  // stalls at all, and two very long holds that back the block up until
  // its input stalls while the sender keeps offering.
  initial begin : result_sink
    int  hold;
    int  taken;
    bit  calm;
    out_stall <= 1'b0;
    taken = 0;
    calm  = 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      if (taken % 40 == 0) calm = ($urandom_range(0, 3) == 0);
      if (taken == 300 || taken == 1000) hold = 600;
      else hold = calm ? 0 : int'($urandom_range(0, 13));
      if (hold > 0) begin
        out_stall <= 1'b1;
        repeat (hold) @(posedge clk);
      end
      out_stall <= 1'b0;
      do @(posedge clk); while (!(out_valid && !out_stall));
      taken++;
    end
  end

  initial begin : stimulus
    int       ph, n, pick, cx, cy, x0, y0;
    ray_txn_t t;

    // Every input known from time zero
    rst_n          <= 1'b0;
    in_valid       <= 1'b0;
    in_func        <= FUNC_WRITE;
    in_slot        <= '0;
    in_slot_active <= 1'b0;
    in_box_x       <= '0;
    in_box_y       <= '0;
    in_box_w       <= '0;
    in_box_h       <= '0;
    in_start_x     <= '0;
    in_start_y     <= '0;
    in_end_x       <= '0;
    in_end_y       <= '0;
    in_self_slot   <= '0;
    burst = 1'b0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // ---- Directed part ----
    // Ray on an empty table, then a corner box at the low extremes.
    offer(mk_cast(-5, -5, 5, 7, SELF_NONE));
    offer(mk_write(0, 1'b1, CMIN, CMIN, 255, 255));
    // Start inside the box: hit right at the start point
    offer(mk_cast(CMIN, CMIN, CMIN + 8, CMIN + 18, SELF_NONE));
    // Same ray cast by the box's owner: box skipped, walk reaches the end
    offer(mk_cast(CMIN, CMIN, CMIN + 8, CMIN + 18, 0));
    // Start equal to end inside the box: end point never tested
    offer(mk_cast(-2000, -2000, -2000, -2000, SELF_NONE));
    // Degenerate boxes: zero width, zero height, zero both at the top corner
    offer(mk_write(6, 1'b1, 100, 100, 0, 50));
    offer(mk_write(5, 1'b1, 200, 100, 50, 0));
    offer(mk_write(7, 1'b1, CMAX, CMAX, 0, 0));
    offer(mk_cast(90, 110, 110, 110, SELF_NONE));
    offer(mk_cast(210, 90, 210, 110, SELF_NONE));
    // Small box, half-open edges from both sides
    offer(mk_write(3, 1'b1, 10, 10, 5, 5));
    offer(mk_cast(0, 0, 20, 20, 15));
    offer(mk_cast(0, 12, 30, 12, SELF_NONE));
    offer(mk_cast(15, 10, 25, 10, SELF_NONE));
    offer(mk_cast(20, 12, 5, 12, SELF_NONE));
    offer(mk_cast(12, 20, 12, 0, SELF_NONE));
    // Inactive write takes the box out of play
    offer(mk_write(3, 1'b0, 10, 10, 5, 5));
    offer(mk_cast(0, 12, 30, 12, SELF_NONE));
    // Unit box just left of and above the origin
    offer(mk_write(4, 1'b1, -1, -1, 1, 1));
    offer(mk_cast(-5, -1, 5, -1, SELF_NONE));
    // Full-span rays: both diagonals and one steep line
    offer(mk_cast(CMIN, CMIN, CMAX, CMAX, 0));
    offer(mk_cast(CMAX, CMIN, CMIN, CMAX, SELF_NONE));
    offer(mk_cast(0, CMIN, 1, CMAX, SELF_NONE));
    // Big box at the high corner, hit at the start
    offer(mk_write(2, 1'b1, CMAX, CMAX, 255, 255));
    offer(mk_cast(CMAX, CMAX, CMAX - 7, CMAX - 7, SELF_NONE));
    drain();

    // ---- Random part ----
    // Phases of 50 transactions share a neighborhood so boxes and rays meet.
    for (ph = 0; ph < 29; ph++) begin
      if ($urandom_range(0, 5) == 0) begin
        cx = $urandom_range(0, 1) ? CMAX : CMIN;
        cy = $urandom_range(0, 1) ? CMAX : CMIN;
      end else begin
        cx = int'($urandom_range(0, 3800)) - 1900;
        cy = int'($urandom_range(0, 3800)) - 1900;
      end
      burst = ($urandom_range(0, 3) == 0);
      for (n = 0; n < 50; n++) begin
        pick = $urandom_range(0, 99);
        if (pick < 3) begin
          // Noise: box anywhere, any size
          t = mk_write($urandom_range(0, 7), $urandom_range(0, 1) != 0, rnd_coord(),
                       rnd_coord(), $urandom_range(0, 255), $urandom_range(0, 255));
        end else if (pick < 30) begin
          pick = $urandom_range(0, 9);
          t = mk_write($urandom_range(0, 7), $urandom_range(0, 4) != 0,
                       nudge(cx, 150), nudge(cy, 150),
                       (pick == 0) ? 0 : (pick < 3) ? $urandom_range(0, 255)
                                                   : $urandom_range(1, 40),
                       (pick == 1) ? 0 : (pick < 3) ? $urandom_range(0, 255)
                                                   : $urandom_range(1, 40));
        end else begin
          pick = $urandom_range(0, 99);
          if (pick < 5) begin
            x0 = rnd_coord();
            y0 = rnd_coord();
          end else begin
            x0 = nudge(cx, 200);
            y0 = nudge(cy, 200);
          end
          if (pick >= 5 && pick < 8)
            // Occasional long ray across the world
            t = mk_cast(x0, y0, rnd_coord(), rnd_coord(), 0);
          else
            t = mk_cast(x0, y0, nudge(x0, 60), nudge(y0, 60), 0);
          t.self_id = SELF_FIELD_W'(($urandom_range(0, 9) == 0) ? $urandom_range(9, 15)
                                                                : $urandom_range(0, 8));
        end
        offer(t);
      end
      // Once mid-run the sender pauses until the block has fully emptied
      if (ph == 14) drain();
    end

    drain();
    repeat (16) @(posedge clk);
    if (mismatch_cnt == 0)
      $display("== PASS ==");
    else
      $display("== FAIL ==");
    $finish;
  end

endmodule
